// ===== hdl/sks_pkg.sv =====
`default_nettype none

package sks_pkg;

  localparam int unsigned KeyWidth = 16;
  localparam int unsigned TagWidth = 16;

  // One slot of the sorting chain.
  typedef struct packed {
    logic                valid;
    logic [KeyWidth-1:0] key;
    logic [TagWidth-1:0] tag;
  } entry_t;

  // Chain-wide control, same for every cell.
  typedef struct packed {
    logic insert_en;  // a word is being inserted this cycle
    logic drain_en;   // chain shifts one slot toward cell 0
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/sks_cell.sv =====
`default_nettype none

module sks_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sks_pkg::cell_ctrl_t  ctrl_i,
  input  sks_pkg::entry_t      new_i,       // broadcast incoming pair
  input  sks_pkg::entry_t      prev_i,      // neighbor toward the head
  input  wire                  prev_ins_i,  // neighbor moves this cycle
  input  sks_pkg::entry_t      next_i,      // neighbor toward the tail
  output sks_pkg::entry_t      cell_o,
  output logic                 ins_o
);

  logic                              valid_q, valid_d;
  logic [sks_pkg::KeyWidth-1:0]      key_q, key_d;
  logic [sks_pkg::TagWidth-1:0]      tag_q, tag_d;
  logic                              load;
  sks_pkg::entry_t                   src;

  // Empty slots count as holding an infinitely large key; strict compare
  // keeps equal keys in arrival order.
  assign ins_o = !valid_q || ($signed(key_q) > $signed(new_i.key));

  always_comb begin
    load = 1'b0;
    src  = next_i;
    if (ctrl_i.drain_en) begin
      load = 1'b1;
      src  = next_i;
    end else if (ctrl_i.insert_en && ins_o) begin
      load = 1'b1;
      src  = prev_ins_i ? prev_i : new_i;
    end
    valid_d = load ? src.valid : valid_q;
    key_d   = load ? src.key   : key_q;
    tag_d   = load ? src.tag   : tag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign cell_o = '{valid: valid_q, key: key_q, tag: tag_q};

endmodule

`default_nettype wire

// ===== hdl/stable_key_tag_sorter.sv =====
`default_nettype none

// Channel   Dir  tdata (low bit up)                 tlast       tuser
// s_axis    in   score[15:0], tag[31:16]             final_item  -
// m_axis    out  sorted_score[15:0], sorted_tag[31:16] end_of_run  dropped
//
// Fill: one word accepted per cycle; it is inserted into a chain of
// MAX_ITEMS cells, or dropped if the last cell is full; each cell compares
// against the broadcast key in parallel. The word with tlast closes the set;
// input stalls while the set drains, one sorted word per cycle from cell 0
// while m_axis_tready_i is high, as the chain shifts toward the head.
// Reset clears all valid bits and the drop flag; no clearing pass.
// Output stalls hold the chain still; the result sits in cell 0's registers.

module stable_key_tag_sorter #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,   // score[15:0], tag[31:16]
  input  wire         s_axis_tlast_i,   // final_item
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // sorted_score[15:0], sorted_tag[31:16]
  output logic        m_axis_tlast_o,   // end_of_run
  output logic        m_axis_tuser_o    // dropped
);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic state_q, state_d;
  logic drop_q, drop_d;

  sks_pkg::entry_t    cells [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] ins;
  logic [MAX_ITEMS-1:0] valid_vec;
  sks_pkg::entry_t    new_entry;
  sks_pkg::entry_t    tail_entry;
  sks_pkg::cell_ctrl_t ctrl;

  logic in_acc, out_acc, full, last_out;

  assign s_axis_tready_o = (state_q == ST_FILL);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign full    = cells[MAX_ITEMS-1].valid;  // chain fills from the head

  assign new_entry  = '{valid: 1'b1, key: s_axis_tdata_i[15:0], tag: s_axis_tdata_i[31:16]};
  assign tail_entry = '{valid: 1'b0, key: '0, tag: '0};

  assign ctrl.insert_en = in_acc && !full;
  assign ctrl.drain_en  = out_acc;

  // Cell i moves when its key exceeds the new one; it takes its neighbor's
  // pair if that one moves too, else the new pair lands here.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    sks_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_i      (new_entry),
      .prev_i     ((i == 0) ? new_entry : cells[(i == 0) ? 0 : i-1]),
      .prev_ins_i ((i == 0) ? 1'b0 : ins[(i == 0) ? 0 : i-1]),
      .next_i     ((i == MAX_ITEMS-1) ? tail_entry
                                      : cells[(i == MAX_ITEMS-1) ? i : i+1]),
      .cell_o     (cells[i]),
      .ins_o      (ins[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  // Last word of the set: nothing stored behind the head.
  assign last_out = !cells[1].valid;

  always_comb begin
    state_d = state_q;
    drop_d  = drop_q;
    unique case (state_q)
      ST_FILL: begin
        if (in_acc) begin
          if (full) begin
            drop_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc && last_out) begin
          state_d = ST_FILL;
          drop_d  = 1'b0;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      drop_q  <= drop_d;
    end
  end

  assign m_axis_tvalid_o = (state_q == ST_DRAIN) && cells[0].valid;
  assign m_axis_tdata_o  = {cells[0].tag, cells[0].key};
  assign m_axis_tlast_o  = last_out;
  assign m_axis_tuser_o  = drop_q;

  // Occupied cells always form a contiguous run from the head.
  a_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("chain has a hole");

  // While draining there is always a word at the head.
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> cells[0].valid)
    else $error("drain with empty chain");

  // A word arriving on a full chain marks the set as dropped.
  a_drop_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full) |=> drop_q)
    else $error("overflow not flagged");

  // After the closing word leaves, the chain is empty and input reopens.
  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_out) |=> (valid_vec == '0) && (state_q == ST_FILL) && !drop_q)
    else $error("chain not empty after drain");

endmodule

`default_nettype wire
